// ===== design/iole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iole_pkg
// shared types and constants for the indexed ordered list engine
// ----------------------------------------------------------------------------
package iole_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int HANDLE_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int ACTION_WIDTH     = 3;
    localparam int POS_WIDTH        = 7;
    localparam int HANDLE_IO_WIDTH  = 32;
    localparam int STATUS_WIDTH     = 2;
    localparam int POS_OUT_WIDTH    = 6;
    localparam int COUNT_WIDTH      = 7;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_INSERT = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_GET    = 3'd3,
        ACT_PUT    = 3'd4,
        ACT_FIND   = 3'd5
    } action_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH
    } ctrl_state_t;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE,
        CELL_SEED,
        CELL_SCAN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     find_mode;
    } cell_ctrl_t;

endpackage

// ===== design/iole_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iole_cell
// one list slot with shift links and a collect stage for position/find scans
// ----------------------------------------------------------------------------
module iole_cell
    import iole_pkg::*;
#(
    parameter int          HANDLE_WIDTH = HANDLE_WIDTH_DEF,
    parameter int          INDEX_WIDTH  = 6,
    parameter int          POS_BITS     = POS_WIDTH,
    parameter int unsigned INDEX        = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic [POS_BITS-1:0]     op_pos,
    input  logic [POS_BITS-1:0]     fill,
    input  logic [HANDLE_WIDTH-1:0] key,
    input  logic [HANDLE_WIDTH-1:0] below_slot,
    input  logic [HANDLE_WIDTH-1:0] above_slot,
    input  logic                    above_valid,
    input  logic [HANDLE_WIDTH-1:0] above_handle,
    input  logic [INDEX_WIDTH-1:0]  above_index,
    output logic [HANDLE_WIDTH-1:0] slot,
    output logic                    col_valid,
    output logic [HANDLE_WIDTH-1:0] col_handle,
    output logic [INDEX_WIDTH-1:0]  col_index
);

    localparam logic [POS_BITS-1:0]    MY_POS   = POS_BITS'(INDEX);
    localparam logic [INDEX_WIDTH-1:0] MY_INDEX = INDEX_WIDTH'(INDEX);

    logic [HANDLE_WIDTH-1:0] slot_reg, slot_next;
    logic                    match_reg, match_next;
    logic                    col_valid_reg, col_valid_next;
    logic [HANDLE_WIDTH-1:0] col_handle_reg, col_handle_next;
    logic [INDEX_WIDTH-1:0]  col_index_reg, col_index_next;
    logic                    own_hit;

    always_comb
    begin
        if (ctrl.find_mode)
        begin
            own_hit = (MY_POS < fill) && (slot_reg == key);
        end
        else
        begin
            own_hit = (MY_POS == op_pos);
        end
    end

    // slot update
    always_comb
    begin
        slot_next = slot_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_POS > op_pos)
                begin
                    slot_next = below_slot;
                end
                else if (MY_POS == op_pos)
                begin
                    slot_next = key;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_POS >= op_pos)
                begin
                    slot_next = above_slot;
                end
            end
            CELL_WRITE:
            begin
                if (MY_POS == op_pos)
                begin
                    slot_next = key;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    // collect stage: lowest hit ripples toward cell 0, one cell per cycle
    always_comb
    begin
        match_next      = match_reg;
        col_valid_next  = col_valid_reg;
        col_handle_next = col_handle_reg;
        col_index_next  = col_index_reg;
        unique case (ctrl.op)
            CELL_SEED:
            begin
                match_next      = own_hit;
                col_valid_next  = own_hit;
                col_handle_next = slot_reg;
                col_index_next  = MY_INDEX;
            end
            CELL_SCAN:
            begin
                if (!match_reg)
                begin
                    col_valid_next  = above_valid;
                    col_handle_next = above_handle;
                    col_index_next  = above_index;
                end
            end
            default:
            begin
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        col_handle_reg <= col_handle_next;
        col_index_reg  <= col_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= 1'b0;
            col_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg     <= match_next;
            col_valid_reg <= col_valid_next;
        end
    end

    assign slot       = slot_reg;
    assign col_valid  = col_valid_reg;
    assign col_handle = col_handle_reg;
    assign col_index  = col_index_reg;

endmodule

// ===== design/iole_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iole_ctrl
// action sequencer: range checks, cell commands, fill count and result register
// ----------------------------------------------------------------------------
module iole_ctrl
    import iole_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
    parameter int INDEX_WIDTH  = 6,
    parameter int FILL_WIDTH   = 7,
    parameter int POS_BITS     = 7
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_WIDTH-1:0]    action,
    input  logic [POS_WIDTH-1:0]       position,
    input  logic [HANDLE_IO_WIDTH-1:0] handle_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_WIDTH-1:0]    status,
    output logic [POS_OUT_WIDTH-1:0]   position_out,
    output logic [HANDLE_IO_WIDTH-1:0] handle_out,
    output logic [COUNT_WIDTH-1:0]     count,
    output cell_ctrl_t                 cell_ctrl,
    output logic [POS_BITS-1:0]        op_pos,
    output logic [POS_BITS-1:0]        fill_pos,
    output logic [HANDLE_WIDTH-1:0]    key,
    input  logic                       col0_valid,
    input  logic [HANDLE_WIDTH-1:0]    col0_handle,
    input  logic [INDEX_WIDTH-1:0]     col0_index
);

    ctrl_state_t             state_reg, state_next;
    logic [ACTION_WIDTH-1:0] act_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic [HANDLE_WIDTH-1:0] key_reg;
    logic [FILL_WIDTH-1:0]   fill_reg, fill_next;
    logic [INDEX_WIDTH-1:0]  step_reg, step_next;

    logic                       out_valid_reg;
    logic [STATUS_WIDTH-1:0]    status_reg;
    logic [POS_OUT_WIDTH-1:0]   position_out_reg;
    logic [HANDLE_IO_WIDTH-1:0] handle_out_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;

    logic                    accept;
    logic                    out_free;
    logic [POS_BITS-1:0]     fill_ext;
    logic [POS_BITS-1:0]     eff_pos;
    logic                    full;

    // decision signals shared by next-state and output logic
    logic                    need_search;
    logic                    res_load;
    status_t                 res_status;
    logic [POS_OUT_WIDTH-1:0] res_pos;
    logic [HANDLE_IO_WIDTH-1:0] res_handle;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fill_ext = POS_BITS'(fill_reg);
    assign full     = (fill_reg == FILL_WIDTH'(CAPACITY));
    assign eff_pos  = (action_t'(act_reg) == ACT_APPEND) ? fill_ext : pos_reg;

    // result and search decision
    always_comb
    begin
        need_search = 1'b0;
        res_status  = STS_OK;
        res_pos     = '0;
        res_handle  = '0;
        if (state_reg == S_DECIDE)
        begin
            unique case (action_t'(act_reg))
                ACT_INSERT, ACT_APPEND:
                begin
                    if (eff_pos > fill_ext)
                    begin
                        res_status = STS_BAD_INDEX;
                    end
                    else if (full)
                    begin
                        res_status = STS_FULL;
                    end
                    else
                    begin
                        res_pos = POS_OUT_WIDTH'(eff_pos);
                    end
                end
                ACT_REMOVE, ACT_GET, ACT_PUT:
                begin
                    if (pos_reg >= fill_ext)
                    begin
                        res_status = STS_BAD_INDEX;
                    end
                    else
                    begin
                        need_search = 1'b1;
                    end
                end
                ACT_FIND:
                begin
                    if (fill_reg == '0)
                    begin
                        res_status = STS_NOT_FOUND;
                    end
                    else
                    begin
                        need_search = 1'b1;
                    end
                end
                default:
                begin
                    res_status = STS_BAD_INDEX;
                end
            endcase
        end
        else
        begin
            if (action_t'(act_reg) == ACT_FIND)
            begin
                if (col0_valid)
                begin
                    res_pos = POS_OUT_WIDTH'(col0_index);
                end
                else
                begin
                    res_status = STS_NOT_FOUND;
                end
            end
            else
            begin
                res_handle = HANDLE_IO_WIDTH'(col0_handle);
            end
        end
    end

    assign res_load = out_free &&
                      (((state_reg == S_DECIDE) && !need_search) ||
                       ((state_reg == S_SEARCH) && (step_reg == '0)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (need_search)
                begin
                    state_next = S_SEARCH;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: cell commands, fill and scan counter
    always_comb
    begin
        cell_ctrl.op        = CELL_HOLD;
        cell_ctrl.find_mode = (action_t'(act_reg) == ACT_FIND);
        fill_next           = fill_reg;
        step_next           = step_reg;
        in_ready            = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cell_ctrl.op = CELL_HOLD;
            end
            S_DECIDE:
            begin
                if (need_search)
                begin
                    cell_ctrl.op = CELL_SEED;
                    if (action_t'(act_reg) == ACT_FIND)
                    begin
                        step_next = INDEX_WIDTH'(fill_reg - 1'b1);
                    end
                    else
                    begin
                        step_next = INDEX_WIDTH'(pos_reg);
                    end
                end
                else if (res_load && (res_status == STS_OK))
                begin
                    cell_ctrl.op = CELL_INSERT;
                    fill_next    = fill_reg + 1'b1;
                end
            end
            S_SEARCH:
            begin
                if (step_reg != '0)
                begin
                    cell_ctrl.op = CELL_SCAN;
                    step_next    = step_reg - 1'b1;
                end
                else if (res_load)
                begin
                    if (action_t'(act_reg) == ACT_PUT)
                    begin
                        cell_ctrl.op = CELL_WRITE;
                    end
                    else if (action_t'(act_reg) == ACT_REMOVE)
                    begin
                        cell_ctrl.op = CELL_REMOVE;
                        fill_next    = fill_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                cell_ctrl.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            pos_reg <= POS_BITS'(position);
            key_reg <= HANDLE_WIDTH'(handle_in);
        end
        if (res_load)
        begin
            status_reg       <= res_status;
            position_out_reg <= res_pos;
            handle_out_reg   <= res_handle;
            count_reg        <= COUNT_WIDTH'(fill_next);
        end
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position_out = position_out_reg;
    assign handle_out   = handle_out_reg;
    assign count        = count_reg;
    assign op_pos       = eff_pos;
    assign fill_pos     = fill_ext;
    assign key          = key_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_WIDTH'(CAPACITY))
        else $error("fill count past capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (FILL_WIDTH'(step_reg) < fill_reg))
        else $error("scan counter outside the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (state_reg == S_SEARCH) && (action_t'(act_reg) == ACT_REMOVE))
        |=> (fill_reg == FILL_WIDTH'($past(fill_reg) - 1'b1)))
        else $error("remove did not shrink the list");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (state_reg != S_IDLE))
        else $error("result loaded with no item in flight");
`endif

endmodule

// ===== design/indexed_ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine_core
// ordered handle list held in a chain of cells: insert, append, remove,
// get, put and find by position or value
// ----------------------------------------------------------------------------
// sequence: insert, append and failed checks give their result from the decide
//   state; get, put and remove at p and find seed the cells and scan, the collect
//   wave moving one cell per cycle from cell p or the last entry to cell 0
// throughput: one item at a time; next item taken the cycle after the result
//   is registered
// reset: rst_n clears the entry count and control state; slot contents are
//   not cleared and are never read before being written
// ----------------------------------------------------------------------------
module indexed_ordered_list_engine_core
    import iole_pkg::*;
#(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ACTION_WIDTH-1:0]    action,
    input  logic [POS_WIDTH-1:0]       position,
    input  logic [HANDLE_IO_WIDTH-1:0] handle_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_WIDTH-1:0]    status,
    output logic [POS_OUT_WIDTH-1:0]   position_out,
    output logic [HANDLE_IO_WIDTH-1:0] handle_out,
    output logic [COUNT_WIDTH-1:0]     count
);

    // index of a cell, entry count, and a compare width wide enough for both
    // the position field and the count
    localparam int INDEX_WIDTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_WIDTH  = $clog2(CAPACITY + 1);
    localparam int POS_BITS    = (FILL_WIDTH > POS_WIDTH) ? FILL_WIDTH : POS_WIDTH;

    cell_ctrl_t              cell_ctrl;
    logic [POS_BITS-1:0]     op_pos;
    logic [POS_BITS-1:0]     fill_pos;
    logic [HANDLE_WIDTH-1:0] key;

    // chain links; the extra top element is the empty end of the chain
    logic [HANDLE_WIDTH-1:0] slot_w       [CAPACITY+1];
    logic                    col_valid_w  [CAPACITY+1];
    logic [HANDLE_WIDTH-1:0] col_handle_w [CAPACITY+1];
    logic [INDEX_WIDTH-1:0]  col_index_w  [CAPACITY+1];

    assign slot_w[CAPACITY]       = '0;
    assign col_valid_w[CAPACITY]  = 1'b0;
    assign col_handle_w[CAPACITY] = '0;
    assign col_index_w[CAPACITY]  = '0;

    // sequencer: checks the action against the count, steps the cells and
    // holds the result until the consumer takes it
    iole_ctrl #(
        .CAPACITY     (CAPACITY),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .INDEX_WIDTH  (INDEX_WIDTH),
        .FILL_WIDTH   (FILL_WIDTH),
        .POS_BITS     (POS_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .position     (position),
        .handle_in    (handle_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position_out (position_out),
        .handle_out   (handle_out),
        .count        (count),
        .cell_ctrl    (cell_ctrl),
        .op_pos       (op_pos),
        .fill_pos     (fill_pos),
        .key          (key),
        .col0_valid   (col_valid_w[0]),
        .col0_handle  (col_handle_w[0]),
        .col0_index   (col_index_w[0])
    );

    // row of cells: insert pulls from the cell below, remove from the cell
    // above; the collect wave runs from high index toward cell 0
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [HANDLE_WIDTH-1:0] below;

        if (g == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_rest
            assign below = slot_w[g-1];
        end

        iole_cell #(
            .HANDLE_WIDTH (HANDLE_WIDTH),
            .INDEX_WIDTH  (INDEX_WIDTH),
            .POS_BITS     (POS_BITS),
            .INDEX        (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .op_pos       (op_pos),
            .fill         (fill_pos),
            .key          (key),
            .below_slot   (below),
            .above_slot   (slot_w[g+1]),
            .above_valid  (col_valid_w[g+1]),
            .above_handle (col_handle_w[g+1]),
            .above_index  (col_index_w[g+1]),
            .slot         (slot_w[g]),
            .col_valid    (col_valid_w[g]),
            .col_handle   (col_handle_w[g]),
            .col_index    (col_index_w[g])
        );
    end

endmodule

// ===== test/list_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// follows both channels of the list engine, keeps its own copy of the list,
// works out the result of every item taken and compares each returned result
// field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module list_result_checker
    import iole_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [ACTION_WIDTH-1:0]    action,
    input  logic [POS_WIDTH-1:0]       position,
    input  logic [HANDLE_IO_WIDTH-1:0] handle_in,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [STATUS_WIDTH-1:0]    status,
    input  logic [POS_OUT_WIDTH-1:0]   position_out,
    input  logic [HANDLE_IO_WIDTH-1:0] handle_out,
    input  logic [COUNT_WIDTH-1:0]     count,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        status_t                    status;
        logic [POS_OUT_WIDTH-1:0]   position;
        logic [HANDLE_IO_WIDTH-1:0] handle;
        logic [COUNT_WIDTH-1:0]     count;
    } list_result_t;

    localparam int PRINT_CAP = 100;

    logic [HANDLE_IO_WIDTH-1:0] slot_store [CAPACITY_DEF];
    int                         list_fill    = 0;
    int                         mismatches   = 0;
    int                         results_seen = 0;
    list_result_t               expected_results [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ERROR %s", $time, msg);
    endtask

    // applies one action to the local list copy and returns its result
    function automatic list_result_t apply_list_action(
        input logic [ACTION_WIDTH-1:0]    act,
        input logic [POS_WIDTH-1:0]       pos,
        input logic [HANDLE_IO_WIDTH-1:0] h
    );
        list_result_t r;
        int           at;
        logic         hit;
        r.status   = STS_OK;
        r.position = '0;
        r.handle   = '0;
        hit        = 1'b0;
        case (act)
            ACT_INSERT, ACT_APPEND:
            begin
                at = (act == ACT_APPEND) ? list_fill : int'(pos);
                // past-the-end index wins over the full check
                if (at > list_fill)
                    r.status = STS_BAD_INDEX;
                else if (list_fill >= CAPACITY_DEF)
                    r.status = STS_FULL;
                else
                begin
                    for (int i = list_fill; i > at; i--)
                        slot_store[i] = slot_store[i - 1];
                    slot_store[at] = h;
                    list_fill++;
                    r.position = at[POS_OUT_WIDTH-1:0];
                end
            end
            ACT_REMOVE, ACT_GET, ACT_PUT:
            begin
                at = int'(pos);
                if (at >= list_fill)
                    r.status = STS_BAD_INDEX;
                else
                begin
                    r.handle = slot_store[at];
                    if (act == ACT_REMOVE)
                    begin
                        for (int i = at; i + 1 < list_fill; i++)
                            slot_store[i] = slot_store[i + 1];
                        list_fill--;
                    end
                    else if (act == ACT_PUT)
                        slot_store[at] = h;
                end
            end
            ACT_FIND:
            begin
                for (int i = 0; i < list_fill && !hit; i++)
                begin
                    if (slot_store[i] == h)
                    begin
                        hit        = 1'b1;
                        r.position = i[POS_OUT_WIDTH-1:0];
                    end
                end
                if (!hit)
                    r.status = STS_NOT_FOUND;
            end
            default:
                r.status = STS_BAD_INDEX;
        endcase
        r.count = list_fill[COUNT_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (!rst_n)
            list_fill = 0;
        else
        begin
            if (in_valid && in_ready)
            begin
                want = apply_list_action(action, position, handle_in);
                expected_results.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("result %0d status: expected %0d got %0d",
                                                  results_seen, want.status, status));
                    if (position_out !== want.position)
                        report_mismatch($sformatf("result %0d position: expected %0d got %0d",
                                                  results_seen, want.position, position_out));
                    if (handle_out !== want.handle)
                        report_mismatch($sformatf("result %0d handle: expected 0x%h got 0x%h",
                                                  results_seen, want.handle, handle_out));
                    if (count !== want.count)
                        report_mismatch($sformatf("result %0d count: expected %0d got %0d",
                                                  results_seen, want.count, count));
                end
                results_seen++;
            end
        end
        fail_count <= mismatches;
        pending    <= expected_results.size();
    end

endmodule

// ===== test/tb_indexed_ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_ordered_list_engine_core
// drives the list engine with a directed opening (empty list, front, middle
// and end inserts, reads, replaces, removes, finds, unused action codes) and
// then random items that swing the list between empty and full; both sides
// stall at random and a side checker compares every result
// ----------------------------------------------------------------------------
module tb_indexed_ordered_list_engine_core;
    import iole_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 550;
    // find on a full list, like an access to the last entry, is the slowest action
    localparam int DRAIN_CYCLES = CAPACITY_DEF + 40;
    // sized for every item being slowest (longest gap, full-list scan, longest stall), ~580 items, ~7x margin
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int MAX_WAIT     = 15;

    // action codes the block does not define; they must come back as bad index
    localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_HI = 3'd7;

    localparam logic [POS_WIDTH-1:0] POS_TOP = '1;

    // random phases: grow the list toward full, drain it toward empty, or mix
    typedef enum int {
        FILL_UP,
        DRAIN_DOWN,
        CHURN
    } stim_mode_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [ACTION_WIDTH-1:0]    action       = '0;
    logic [POS_WIDTH-1:0]       position     = '0;
    logic [HANDLE_IO_WIDTH-1:0] handle_in    = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic [STATUS_WIDTH-1:0]    status;
    logic [POS_OUT_WIDTH-1:0]   position_out;
    logic [HANDLE_IO_WIDTH-1:0] handle_out;
    logic [COUNT_WIDTH-1:0]     count;

    int fail_count;
    int pending;

    // stimulus-side view of the list length, used to aim positions and to steer between filling and draining
    int                         len_shadow = 0;
    stim_mode_t                 drive_mode = FILL_UP;
    logic                       in_burst   = 1'b0;
    logic                       out_burst  = 1'b0;
    logic [HANDLE_IO_WIDTH-1:0] handle_pool [8];

    always #(CLK_PERIOD / 2) clk = ~clk;

    indexed_ordered_list_engine_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .position     (position),
        .handle_in    (handle_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position_out (position_out),
        .handle_out   (handle_out),
        .count        (count)
    );

    list_result_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .position     (position),
        .handle_in    (handle_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position_out (position_out),
        .handle_out   (handle_out),
        .count        (count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // offers one item after a random gap and holds it until taken;
    // valid is only lowered when a gap is drawn, so back-to-back items
    // never see a low and a high scheduled in the same step
    task automatic send_item(
        input logic [ACTION_WIDTH-1:0]    act,
        input logic [POS_WIDTH-1:0]       pos,
        input logic [HANDLE_IO_WIDTH-1:0] h
    );
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        position  <= pos;
        handle_in <= h;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // follow the length so later positions land near the ends
        case (act)
            ACT_INSERT:
                if (int'(pos) <= len_shadow && len_shadow < CAPACITY_DEF)
                    len_shadow++;
            ACT_APPEND:
                if (len_shadow < CAPACITY_DEF)
                    len_shadow++;
            ACT_REMOVE:
                if (int'(pos) < len_shadow)
                    len_shadow--;
            default:
                ;
        endcase
    endtask

    // mostly in range with the ends favored, one in ten out of range
    function automatic logic [POS_WIDTH-1:0] pick_position(input logic [ACTION_WIDTH-1:0] act);
        int last;
        int roll;
        if (act == ACT_INSERT)
            last = len_shadow;
        else if (act == ACT_REMOVE || act == ACT_GET || act == ACT_PUT)
            last = len_shadow - 1;
        else
            return POS_WIDTH'($urandom_range(0, int'(POS_TOP)));
        roll = $urandom_range(0, 9);
        if (roll == 0 || last < 0)
            return POS_WIDTH'($urandom_range(last + 1, int'(POS_TOP)));
        else if (roll < 3)
            return '0;
        else if (roll < 5)
            return POS_WIDTH'(last);
        return POS_WIDTH'($urandom_range(0, last));
    endfunction

    // a small pool of repeated handles makes finds hit and duplicates appear
    function automatic logic [HANDLE_IO_WIDTH-1:0] pick_handle();
        if ($urandom_range(0, 9) < 6)
            return handle_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    task automatic send_random_item();
        int                      roll;
        logic [ACTION_WIDTH-1:0] act;
        roll = $urandom_range(0, 99);
        case (drive_mode)
            FILL_UP:
                act = roll < 35 ? ACT_INSERT : roll < 65 ? ACT_APPEND :
                      roll < 71 ? ACT_REMOVE : roll < 81 ? ACT_GET :
                      roll < 88 ? ACT_PUT    : roll < 97 ? ACT_FIND :
                      roll < 98 ? ACT_SPARE_LO : ACT_SPARE_HI;
            DRAIN_DOWN:
                act = roll < 45 ? ACT_REMOVE : roll < 55 ? ACT_INSERT :
                      roll < 60 ? ACT_APPEND : roll < 72 ? ACT_GET :
                      roll < 84 ? ACT_PUT    : roll < 96 ? ACT_FIND :
                      roll < 98 ? ACT_SPARE_LO : ACT_SPARE_HI;
            default:
                act = roll < 18 ? ACT_INSERT : roll < 32 ? ACT_APPEND :
                      roll < 50 ? ACT_REMOVE : roll < 64 ? ACT_GET :
                      roll < 78 ? ACT_PUT    : roll < 94 ? ACT_FIND :
                      roll < 97 ? ACT_SPARE_LO : ACT_SPARE_HI;
        endcase
        send_item(act, pick_position(act), pick_handle());
        // linger a few items at full or empty, then turn around
        if (len_shadow == CAPACITY_DEF && $urandom_range(0, 3) == 0)
            drive_mode = DRAIN_DOWN;
        else if (len_shadow == 0 && $urandom_range(0, 2) == 0)
            drive_mode = FILL_UP;
        else if ($urandom_range(0, 59) == 0)
            drive_mode = stim_mode_t'($urandom_range(0, 2));
    endtask

    // result side: random stall before each result, with stall-free bursts
    initial
    begin : result_sink
        int stall;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            handle_pool[i] = $urandom();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every index is bad and nothing can be found
        send_item(ACT_GET,    '0, '0);
        send_item(ACT_REMOVE, '0, '0);
        send_item(ACT_PUT,    '0, 32'h1357_9BDF);
        send_item(ACT_FIND,   '0, '0);
        // insert past the end, just past and at the top of the field
        send_item(ACT_INSERT, 7'd1,    32'h0BAD_0001);
        send_item(ACT_INSERT, POS_TOP, '1);
        // build [5A.., 00.., A5.., FF..] through end, front and middle inserts
        send_item(ACT_INSERT, '0,      '0);
        send_item(ACT_APPEND, POS_TOP, '1);
        send_item(ACT_INSERT, 7'd1,    32'hA5A5_A5A5);
        send_item(ACT_INSERT, '0,      32'h5A5A_5A5A);
        // find at the end, in the middle, and a miss
        send_item(ACT_FIND,   '0, '1);
        send_item(ACT_FIND,   '0, '0);
        send_item(ACT_FIND,   '0, 32'h1234_5678);
        // read the last entry, then one past it
        send_item(ACT_GET,    7'd3, '0);
        send_item(ACT_GET,    7'd4, '0);
        send_item(ACT_PUT,    '0,   32'hDEAD_BEEF);
        // middle and last removes, then one past the end
        send_item(ACT_REMOVE, 7'd1, '0);
        send_item(ACT_REMOVE, 7'd2, '0);
        send_item(ACT_REMOVE, 7'd2, '0);
        // undefined actions leave the list alone
        send_item(ACT_SPARE_LO, '0,      '0);
        send_item(ACT_SPARE_HI, POS_TOP, '1);
        send_item(ACT_FIND,     '0,      32'hDEAD_BEEF);
        // front removes down to empty
        send_item(ACT_REMOVE, '0, '0);
        send_item(ACT_REMOVE, '0, '0);
        send_item(ACT_GET,    '0, '0);

        // random part starts by growing to full so the full case comes early
        drive_mode = FILL_UP;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                in_burst = !in_burst;
            send_random_item();
        end
        in_valid <= 1'b0;

        // step once so the checker's count includes the last item
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("indexed_ordered_list_engine_core: match");
        else
            $display("indexed_ordered_list_engine_core: mismatch");
        $finish;
    end

    // hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("indexed_ordered_list_engine_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/iole_pkg.sv
design/iole_cell.sv
design/iole_ctrl.sv
design/indexed_ordered_list_engine_core.sv
test/list_result_checker.sv
test/tb_indexed_ordered_list_engine_core.sv
